>>> rtl/core/fseg_pkg.sv
// Shared constants and types for the FCFS schedule event generator.
// Holds store sizing, field widths, event kind codes and the store entry layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fseg_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 24;
    localparam int ID_W      = 4;
    localparam int CLK_W     = 29;
    localparam int KIND_W    = 2;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] rem;
        logic [ID_W-1:0]   id;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/fifo_schedule_event_generator.sv
// FCFS schedule event generator: sorted descriptor store and event sequencer.
// Keeps descriptors in one synchronous entry memory; emits idle/create/run words.
// Depends on fseg_pkg.
// Load: a descriptor is written in arrival order; each stored entry that arrives later moves
// up one slot first, one entry per cycle through memory (0 to MAX_PROCS-1 entries moved).
// Emission, per entry: fetch, idle word for a gap, create when first admitted, then per arrival
// inside the run a split run word if it arrives later and a create, then a closing run step.
// A flush ends the batch; a stalled output holds the sequencer once two words wait.
// Reset clears the entry count, sequencer state and output valid flags; memory contents stay
// undefined and only entries written in the current batch are read.
`timescale 1ns / 1ps
`default_nettype none

module fifo_schedule_event_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fseg_pkg::IN_DATA_W-1:0]  s_tdata,  // start_time[23:0], burst_time[47:24]
    input  wire logic                            s_tlast,  // last_process
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fseg_pkg::OUT_DATA_W-1:0]      m_tdata,  // process_id[3:0], duration[27:4], zero
    output logic [fseg_pkg::KIND_W-1:0]          m_tuser,  // event_kind[1:0]
    output logic                                 m_tlast   // last_event
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_CMP = 4'd1;
    localparam logic [3:0] S_PUT     = 4'd2;
    localparam logic [3:0] S_TOP     = 4'd3;
    localparam logic [3:0] S_LLD     = 4'd4;
    localparam logic [3:0] S_GAP     = 4'd5;
    localparam logic [3:0] S_CRT     = 4'd6;
    localparam logic [3:0] S_INNER   = 4'd7;
    localparam logic [3:0] S_ALD     = 4'd8;
    localparam logic [3:0] S_SPLIT   = 4'd9;
    localparam logic [3:0] S_ACRT    = 4'd10;
    localparam logic [3:0] S_RUN     = 4'd11;
    localparam logic [3:0] S_FLUSH   = 4'd12;

    localparam int TW = fseg_pkg::TIME_W;
    localparam int CW = fseg_pkg::CLK_W;
    localparam int NW = fseg_pkg::CNT_W;
    localparam int IW = fseg_pkg::IDX_W;
    localparam int DW = fseg_pkg::ID_W;
    localparam int KW = fseg_pkg::KIND_W;

    fseg_pkg::entry_t mem [fseg_pkg::MAX_PROCS];
    fseg_pkg::entry_t rd_q_reg;
    fseg_pkg::entry_t wr_data;
    logic             we;
    logic             rd_en;
    logic [IW-1:0]    wr_addr;
    logic [IW-1:0]    rd_addr;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic [NW-1:0] ll_reg, ll_next;
    logic [NW-1:0] adm_reg, adm_next;
    logic [CW-1:0] ctime_reg, ctime_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [DW-1:0] lid_reg, lid_next;
    logic [TW-1:0] st_reg, st_next;
    logic [TW-1:0] bt_reg, bt_next;
    logic          last_reg, last_next;

    logic          hold_valid_reg, hold_valid_next;
    logic [KW-1:0] hold_kind_reg, hold_kind_next;
    logic [DW-1:0] hold_id_reg, hold_id_next;
    logic [TW-1:0] hold_dur_reg, hold_dur_next;
    logic          o_valid_reg, o_valid_next;
    logic [KW-1:0] o_kind_reg, o_kind_next;
    logic [DW-1:0] o_id_reg, o_id_next;
    logic [TW-1:0] o_dur_reg, o_dur_next;
    logic          o_last_reg, o_last_next;

    logic          emit;
    logic [KW-1:0] ev_kind;
    logic [DW-1:0] ev_id;
    logic [TW-1:0] ev_dur;
    logic          out_free;
    logic          can_emit;
    logic          flush;
    logic [NW-1:0] pos_m1;
    logic [NW-1:0] pos_m2;
    logic [CW-1:0] arr_ext;
    logic [CW-1:0] gap;
    logic [CW:0]   run_end;
    logic          arr_after;
    logic          in_window;

    assign pos_m1    = pos_reg - NW'(1);
    assign pos_m2    = pos_reg - NW'(2);
    assign arr_ext   = CW'(rd_q_reg.arr);
    assign gap       = arr_ext - ctime_reg;
    assign run_end   = {1'b0, ctime_reg} + (CW + 1)'(rem_reg);
    assign arr_after = arr_ext > ctime_reg;
    assign in_window = run_end >= (CW + 1)'(rd_q_reg.arr);
    assign out_free  = !o_valid_reg || m_tready;
    assign can_emit  = !hold_valid_reg || out_free;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        ll_next    = ll_reg;
        adm_next   = adm_reg;
        ctime_next = ctime_reg;
        rem_next   = rem_reg;
        lid_next   = lid_reg;
        st_next    = st_reg;
        bt_next    = bt_reg;
        last_next  = last_reg;
        we         = 1'b0;
        wr_addr    = pos_reg[IW-1:0];
        wr_data    = rd_q_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_m1[IW-1:0];
        emit       = 1'b0;
        ev_kind    = fseg_pkg::KIND_IDLE;
        ev_id      = '0;
        ev_dur     = '0;
        flush      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    st_next   = s_tdata[TW-1:0];
                    bt_next   = s_tdata[2*TW-1:TW];
                    last_next = s_tlast;
                    pos_next  = cnt_reg;
                    if (cnt_reg < NW'(fseg_pkg::MAX_PROCS))
                    begin
                        if (cnt_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IW'(cnt_reg - NW'(1));
                            state_next = S_INS_CMP;
                        end
                    end
                    else if (s_tlast)
                    begin
                        ll_next    = '0;
                        adm_next   = '0;
                        ctime_next = '0;
                        state_next = S_TOP;
                    end
                end
            end
            S_INS_CMP:
            begin
                if (rd_q_reg.arr > st_reg)
                begin
                    we       = 1'b1;
                    wr_addr  = pos_reg[IW-1:0];
                    wr_data  = rd_q_reg;
                    pos_next = pos_m1;
                    if (pos_m1 != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_m2[IW-1:0];
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                we       = 1'b1;
                wr_addr  = pos_reg[IW-1:0];
                wr_data  = '{arr: st_reg, rem: bt_reg, id: cnt_reg[DW-1:0]};
                cnt_next = cnt_reg + NW'(1);
                if (last_reg)
                begin
                    ll_next    = '0;
                    adm_next   = '0;
                    ctime_next = '0;
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TOP:
            begin
                if (adm_reg == cnt_reg && ll_reg == adm_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ll_reg[IW-1:0];
                    state_next = S_LLD;
                end
            end
            S_LLD:
            begin
                rem_next = rd_q_reg.rem;
                lid_next = rd_q_reg.id;
                if (ll_reg == adm_reg)
                begin
                    adm_next   = adm_reg + NW'(1);
                    state_next = arr_after ? S_GAP : S_CRT;
                end
                else
                begin
                    state_next = S_INNER;
                end
            end
            S_GAP:
            begin
                emit    = 1'b1;
                ev_kind = fseg_pkg::KIND_IDLE;
                ev_dur  = gap[TW-1:0];
                if (can_emit)
                begin
                    ctime_next = arr_ext;
                    state_next = S_CRT;
                end
            end
            S_CRT:
            begin
                emit    = 1'b1;
                ev_kind = fseg_pkg::KIND_CREATE;
                ev_id   = lid_reg;
                if (can_emit)
                begin
                    state_next = S_INNER;
                end
            end
            S_INNER:
            begin
                if (adm_reg != cnt_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = adm_reg[IW-1:0];
                    state_next = S_ALD;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_ALD:
            begin
                if (in_window)
                begin
                    state_next = arr_after ? S_SPLIT : S_ACRT;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_SPLIT:
            begin
                emit    = 1'b1;
                ev_kind = fseg_pkg::KIND_RUN;
                ev_id   = lid_reg;
                ev_dur  = gap[TW-1:0];
                if (can_emit)
                begin
                    rem_next   = rem_reg - gap[TW-1:0];
                    ctime_next = arr_ext;
                    state_next = S_ACRT;
                end
            end
            S_ACRT:
            begin
                emit    = 1'b1;
                ev_kind = fseg_pkg::KIND_CREATE;
                ev_id   = rd_q_reg.id;
                if (can_emit)
                begin
                    adm_next   = adm_reg + NW'(1);
                    state_next = S_INNER;
                end
            end
            S_RUN:
            begin
                if (rem_reg != '0)
                begin
                    emit    = 1'b1;
                    ev_kind = fseg_pkg::KIND_RUN;
                    ev_id   = lid_reg;
                    ev_dur  = rem_reg;
                    if (can_emit)
                    begin
                        ctime_next = run_end[CW-1:0];
                        rem_next   = '0;
                        ll_next    = ll_reg + NW'(1);
                        state_next = S_TOP;
                    end
                end
                else
                begin
                    ll_next    = ll_reg + NW'(1);
                    state_next = S_TOP;
                end
            end
            S_FLUSH:
            begin
                flush = 1'b1;
                if (out_free)
                begin
                    cnt_next   = '0;
                    ctime_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_id_next    = hold_id_reg;
        hold_dur_next   = hold_dur_reg;
        o_valid_next    = o_valid_reg;
        o_kind_next     = o_kind_reg;
        o_id_next       = o_id_reg;
        o_dur_next      = o_dur_reg;
        o_last_next     = o_last_reg;

        if (o_valid_reg && m_tready)
        begin
            o_valid_next = 1'b0;
        end
        if (emit && can_emit)
        begin
            if (hold_valid_reg)
            begin
                o_valid_next = 1'b1;
                o_kind_next  = hold_kind_reg;
                o_id_next    = hold_id_reg;
                o_dur_next   = hold_dur_reg;
                o_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_kind_next  = ev_kind;
            hold_id_next    = ev_id;
            hold_dur_next   = ev_dur;
        end
        else if (flush && out_free)
        begin
            o_valid_next    = hold_valid_reg;
            o_kind_next     = hold_kind_reg;
            o_id_next       = hold_id_reg;
            o_dur_next      = hold_dur_reg;
            o_last_next     = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            ll_reg         <= '0;
            adm_reg        <= '0;
            ctime_reg      <= '0;
            hold_valid_reg <= 1'b0;
            o_valid_reg    <= 1'b0;
            o_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            ll_reg         <= ll_next;
            adm_reg        <= adm_next;
            ctime_reg      <= ctime_next;
            hold_valid_reg <= hold_valid_next;
            o_valid_reg    <= o_valid_next;
            o_last_reg     <= o_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        lid_reg       <= lid_next;
        st_reg        <= st_next;
        bt_reg        <= bt_next;
        last_reg      <= last_next;
        hold_kind_reg <= hold_kind_next;
        hold_id_reg   <= hold_id_next;
        hold_dur_reg  <= hold_dur_next;
        o_kind_reg    <= o_kind_next;
        o_id_reg      <= o_id_next;
        o_dur_reg     <= o_dur_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {(fseg_pkg::OUT_DATA_W - DW - TW)'(0), o_dur_reg, o_id_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(fseg_pkg::MAX_PROCS))
        else $error("entry count exceeds store depth");

    a_ll_le_adm: assert property (@(posedge clk) disable iff (!rst_n)
        ll_reg <= adm_reg)
        else $error("running entry passed admitted entries");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !hold_valid_reg)
        else $error("held event word while accepting descriptors");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("output word changed while stalled");

endmodule

`default_nettype wire

>>> tb/sv/tb_fifo_schedule_event_generator.sv
// Self-checking bench for fifo_schedule_event_generator: loads descriptor batches,
// predicts the FCFS idle/create/run word sequence and checks every output word.
// Depends on fseg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_fifo_schedule_event_generator;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 310;

    typedef struct {
        logic [fseg_pkg::KIND_W-1:0] kind;
        logic [fseg_pkg::ID_W-1:0]   pid;
        logic [fseg_pkg::TIME_W-1:0] dur;
        logic                        last;
    } sched_word_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [fseg_pkg::IN_DATA_W-1:0]  s_tdata;   // start_time[23:0], burst_time[47:24]
    logic                            s_tlast;   // last_process
    logic                            m_tvalid;
    logic                            m_tready;
    logic [fseg_pkg::OUT_DATA_W-1:0] m_tdata;   // process_id[3:0], duration[27:4], zero
    logic [fseg_pkg::KIND_W-1:0]     m_tuser;   // event_kind[1:0]
    logic                            m_tlast;   // last_event

    // predictor state
    logic [fseg_pkg::TIME_W-1:0] arr_tab   [fseg_pkg::MAX_PROCS];
    logic [fseg_pkg::TIME_W-1:0] burst_tab [fseg_pkg::MAX_PROCS];
    logic [fseg_pkg::ID_W-1:0]   pid_tab   [fseg_pkg::MAX_PROCS];
    int                          held;
    sched_word_t                 schedule_words[$];

    int   error_count;
    int   quiet_cycles;
    int   stall_left;
    bit   calm;

    fifo_schedule_event_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic sched_word_t make_word(logic [fseg_pkg::KIND_W-1:0] kind,
                                              logic [fseg_pkg::ID_W-1:0] pid,
                                              logic [31:0] dur);
        sched_word_t w;
        w.kind = kind;
        w.pid  = pid;
        w.dur  = dur[fseg_pkg::TIME_W-1:0];
        w.last = 1'b0;
        return w;
    endfunction

    // insert one descriptor; on the last one, build the whole FCFS schedule
    task automatic fcfs_load(input logic [fseg_pkg::TIME_W-1:0] st,
                             input logic [fseg_pkg::TIME_W-1:0] bt,
                             input logic lp);
        int          pos;
        int          n;
        int          ll;
        int          adm;
        logic [31:0] now;
        logic [31:0] seg;
        sched_word_t sched[$];
        if (held < fseg_pkg::MAX_PROCS)
        begin
            pos = held;
            while (pos > 0 && arr_tab[pos-1] > st)
            begin
                arr_tab[pos]   = arr_tab[pos-1];
                burst_tab[pos] = burst_tab[pos-1];
                pid_tab[pos]   = pid_tab[pos-1];
                pos--;
            end
            arr_tab[pos]   = st;
            burst_tab[pos] = bt;
            pid_tab[pos]   = fseg_pkg::ID_W'(held);
            held++;
        end
        if (!lp)
            return;
        n   = held;
        ll  = 0;
        adm = 0;
        now = 0;
        while (adm != n || ll < adm)
        begin
            if (ll >= adm)
            begin
                adm++;
                if (arr_tab[ll] > now)
                begin
                    sched.push_back(make_word(fseg_pkg::KIND_IDLE, '0, arr_tab[ll] - now));
                    now = arr_tab[ll];
                end
                sched.push_back(make_word(fseg_pkg::KIND_CREATE, pid_tab[ll], 0));
            end
            while (adm != n && now + burst_tab[ll] >= arr_tab[adm])
            begin
                if (arr_tab[adm] > now)
                begin
                    seg = arr_tab[adm] - now;
                    sched.push_back(make_word(fseg_pkg::KIND_RUN, pid_tab[ll], seg));
                    burst_tab[ll] = burst_tab[ll] - seg[fseg_pkg::TIME_W-1:0];
                    now = now + seg;
                end
                sched.push_back(make_word(fseg_pkg::KIND_CREATE, pid_tab[adm], 0));
                adm++;
            end
            if (burst_tab[ll] != 0)
            begin
                sched.push_back(make_word(fseg_pkg::KIND_RUN, pid_tab[ll], 32'(burst_tab[ll])));
                now = now + 32'(burst_tab[ll]);
                burst_tab[ll] = '0;
            end
            ll++;
        end
        sched[sched.size()-1].last = 1'b1;
        foreach (sched[i])
            schedule_words.push_back(sched[i]);
        held = 0;
    endtask

    task automatic send_descriptor(input logic [fseg_pkg::TIME_W-1:0] st,
                                   input logic [fseg_pkg::TIME_W-1:0] bt,
                                   input logic lp);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bt, st};
        s_tlast  <= lp;
        do
            @(posedge clk);
        while (!s_tready);
        fcfs_load(st, bt, lp);
    endtask

    // hold the sender until the schedule has been drained
    task automatic wait_schedule_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (schedule_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_single_extremes();
        send_descriptor(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        wait_schedule_drained();
        send_descriptor(24'h000000, 24'h000000, 1'b1);
        wait_schedule_drained();
    endtask

    task automatic test_split_tie_and_run_end();
        send_descriptor(24'd0, 24'd5, 1'b0);
        send_descriptor(24'd5, 24'd3, 1'b0);
        send_descriptor(24'd3, 24'd0, 1'b0);
        send_descriptor(24'd5, 24'd2, 1'b1);
        wait_schedule_drained();
    endtask

    task automatic test_store_full();
        for (int i = 0; i <= fseg_pkg::MAX_PROCS; i++)
            send_descriptor(fseg_pkg::TIME_W'($urandom_range(0, 60)),
                            fseg_pkg::TIME_W'($urandom_range(0, 9)),
                            i == fseg_pkg::MAX_PROCS);
        wait_schedule_drained();
    endtask

    task automatic test_random_batches();
        int                          sent;
        int                          size;
        int                          mode;
        int                          m;
        logic [fseg_pkg::TIME_W-1:0] st;
        logic [fseg_pkg::TIME_W-1:0] bt;
        logic [fseg_pkg::TIME_W-1:0] prev;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            size = ($urandom_range(0, 99) < 85)
                   ? $urandom_range(1, fseg_pkg::MAX_PROCS)
                   : $urandom_range(fseg_pkg::MAX_PROCS + 1, fseg_pkg::MAX_PROCS + 4);
            mode = $urandom_range(0, 4);
            prev = '0;
            for (int i = 0; i < size; i++)
            begin
                m = (mode == 4) ? $urandom_range(0, 3) : mode;
                case (m)
                    0:
                    begin
                        st = fseg_pkg::TIME_W'($urandom_range(0, 40));
                        bt = fseg_pkg::TIME_W'($urandom_range(0, 15));
                    end
                    1:
                    begin
                        st = fseg_pkg::TIME_W'($urandom_range(0, 2000));
                        bt = fseg_pkg::TIME_W'($urandom_range(0, 300));
                    end
                    2:
                    begin
                        st = fseg_pkg::TIME_W'($urandom);
                        bt = fseg_pkg::TIME_W'($urandom);
                    end
                    default:
                    begin
                        st = prev + fseg_pkg::TIME_W'($urandom_range(0, 20));
                        bt = fseg_pkg::TIME_W'($urandom_range(0, 25));
                    end
                endcase
                prev = st;
                send_descriptor(st, bt, i == size - 1);
            end
            sent += size;
            if ($urandom_range(0, 7) == 0)
                wait_schedule_drained();
        end
        calm = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin
        sched_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (schedule_words.size() == 0)
            begin
                $error("unexpected word: kind %0d id %0d duration %0d last %0d",
                       m_tuser, m_tdata[3:0], m_tdata[27:4], m_tlast);
                error_count++;
            end
            else
            begin
                exp_w = schedule_words.pop_front();
                if (m_tuser !== exp_w.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", exp_w.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[3:0] !== exp_w.pid)
                begin
                    $error("process_id: expected %0d, got %0d", exp_w.pid, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[27:4] !== exp_w.dur)
                begin
                    $error("duration: expected %0d, got %0d", exp_w.dur, m_tdata[27:4]);
                    error_count++;
                end
                if (m_tlast !== exp_w.last)
                begin
                    $error("last_event: expected %0d, got %0d", exp_w.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_fifo_schedule_event_generator NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        held         = 0;
        error_count  = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        calm         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_extremes();
        test_split_tie_and_run_end();
        test_store_full();
        test_random_batches();

        wait_schedule_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb_fifo_schedule_event_generator OK");
        else
            $display("tb_fifo_schedule_event_generator NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/core/fseg_pkg.sv
rtl/core/fifo_schedule_event_generator.sv
tb/sv/tb_fifo_schedule_event_generator.sv
